// File: design/mpfe_pkg.sv
// ----------------------------------------------------------------------------
// mpfe_pkg
// shared types and constants of the page framebuffer engine
// ----------------------------------------------------------------------------
package mpfe_pkg;

  localparam int PAGE_ROWS   = 8;
  localparam int PAGE_W      = 5;
  localparam int CNT_W       = 14;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_FILL,
    OP_RECT,
    OP_WRITE,
    OP_READ
  } op_t;

  typedef struct packed {
    op_t               op;
    logic              status;
    logic              color;
    logic [7:0]        data;
    logic [9:0]        address;
    logic [7:0]        x_first;
    logic [7:0]        x_last;
    logic [PAGE_W-1:0] page_first;
    logic [PAGE_W-1:0] page_last;
    logic [7:0]        mask_first;
    logic [7:0]        mask_last;
  } cmd_t;

endpackage

// File: design/mpfe_ram.sv
// ----------------------------------------------------------------------------
// mpfe_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module mpfe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/mpfe_front.sv
// ----------------------------------------------------------------------------
// mpfe_front
// accepts commands, checks ranges, clips rectangles and builds queue entries
// ----------------------------------------------------------------------------
module mpfe_front import mpfe_pkg::*; #(
  parameter int DISP_WIDTH  = 128,
  parameter int DISP_HEIGHT = 64
) (
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] func,
  input  logic [7:0] x,
  input  logic [7:0] y,
  input  logic [7:0] width,
  input  logic [7:0] height,
  input  logic       color,
  input  logic [9:0] address,
  input  logic [7:0] data,
  input  logic       q_full,
  input  logic       clearing,
  output logic       push,
  output cmd_t       cmd
);

  localparam int STORE_BYTES = DISP_WIDTH * ((DISP_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS);

  localparam logic [2:0] FUNC_FILL  = 3'd0;
  localparam logic [2:0] FUNC_PIXEL = 3'd1;
  localparam logic [2:0] FUNC_RECT  = 3'd2;
  localparam logic [2:0] FUNC_WRITE = 3'd3;
  localparam logic [2:0] FUNC_READ  = 3'd4;

  localparam logic [8:0] X_LIM = 9'(DISP_WIDTH - 1);
  localparam logic [8:0] Y_LIM = 9'(DISP_HEIGHT - 1);

  logic       start_oob;
  logic       addr_oob;
  logic [8:0] x_end;
  logic [8:0] y_end;
  logic [7:0] x_clip;
  logic [7:0] y_clip;
  logic [7:0] y_last;

  assign in_ready = !q_full && !clearing;
  assign push     = in_valid && in_ready;

  assign start_oob = ({1'b0, x} > X_LIM) || ({1'b0, y} > Y_LIM);
  assign addr_oob  = CNT_W'(address) >= CNT_W'(STORE_BYTES);
  assign x_end     = {1'b0, x} + {1'b0, width} - 9'd1;
  assign y_end     = {1'b0, y} + {1'b0, height} - 9'd1;
  assign x_clip    = (x_end > X_LIM) ? X_LIM[7:0] : x_end[7:0];
  assign y_clip    = (y_end > Y_LIM) ? Y_LIM[7:0] : y_end[7:0];
  assign y_last    = (func == FUNC_RECT) ? y_clip : y;

  always_comb begin
    cmd            = '0;
    cmd.op         = OP_NONE;
    cmd.color      = color;
    cmd.data       = data;
    cmd.address    = address;
    cmd.x_first    = x;
    cmd.x_last     = (func == FUNC_RECT) ? x_clip : x;
    cmd.page_first = y[7:3];
    cmd.page_last  = y_last[7:3];
    cmd.mask_first = 8'hFF << y[2:0];
    cmd.mask_last  = 8'hFF >> (3'd7 - y_last[2:0]);
    case (func)
      FUNC_FILL: begin
        cmd.op = OP_FILL;
      end
      FUNC_PIXEL: begin
        if (start_oob) begin
          cmd.status = 1'b1;
        end else begin
          cmd.op = OP_RECT;
        end
      end
      FUNC_RECT: begin
        if (start_oob) begin
          cmd.status = 1'b1;
        end else if (width != 8'd0 && height != 8'd0) begin
          cmd.op = OP_RECT;
        end
      end
      FUNC_WRITE: begin
        if (addr_oob) begin
          cmd.status = 1'b1;
        end else begin
          cmd.op = OP_WRITE;
        end
      end
      FUNC_READ: begin
        if (addr_oob) begin
          cmd.status = 1'b1;
        end else begin
          cmd.op = OP_READ;
        end
      end
      default: begin
        cmd.op = OP_NONE;
      end
    endcase
  end

endmodule

// File: design/mpfe_queue.sv
// ----------------------------------------------------------------------------
// mpfe_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module mpfe_queue import mpfe_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t pop_cmd
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  cmd_t          entries [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full    = count == CW'(QUEUE_DEPTH);
  assign empty   = count == '0;
  assign pop_cmd = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

// File: design/mpfe_back.sv
// ----------------------------------------------------------------------------
// mpfe_back
// executes queued commands on the frame store and returns one result each
// ----------------------------------------------------------------------------
module mpfe_back import mpfe_pkg::*; #(
  parameter int DISP_WIDTH  = 128,
  parameter int DISP_HEIGHT = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  input  cmd_t       q_cmd,
  output logic       pop,
  output logic       clearing,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  output logic       status
);

  localparam int STORE_BYTES = DISP_WIDTH * ((DISP_HEIGHT + PAGE_ROWS - 1) / PAGE_ROWS);
  localparam int AW          = $clog2(STORE_BYTES);

  localparam logic [AW-1:0] LAST_ADDR = AW'(STORE_BYTES - 1);
  localparam logic [AW-1:0] ROW_STEP  = AW'(DISP_WIDTH);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FILL,
    S_WRITE,
    S_READ,
    S_RMW_RD,
    S_RMW_WR,
    S_DONE
  } state_t;

  state_t            state;
  cmd_t              cur;
  logic [AW-1:0]     addr;
  logic [AW-1:0]     row_base;
  logic [7:0]        col;
  logic [PAGE_W-1:0] page;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [7:0]        ram_wdata;
  logic              ram_re;
  logic [7:0]        ram_rdata;
  logic [7:0]        pmask;
  logic [AW-1:0]     first_base;
  logic              res_free;

  mpfe_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  assign clearing   = state == S_CLEAR;
  assign pop        = (state == S_IDLE) && !q_empty;
  assign res_free   = !out_valid || out_ready;
  assign first_base = AW'(int'(q_cmd.page_first) * DISP_WIDTH);
  assign pmask      = ((page == cur.page_first) ? cur.mask_first : 8'hFF) &
                      ((page == cur.page_last) ? cur.mask_last : 8'hFF);

  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = addr;
    ram_wdata = 8'h00;
    case (state)
      S_CLEAR: begin
        ram_we = 1'b1;
      end
      S_FILL, S_WRITE: begin
        ram_we    = 1'b1;
        ram_wdata = cur.data;
      end
      S_READ, S_RMW_RD: begin
        ram_re = 1'b1;
      end
      S_RMW_WR: begin
        ram_we    = 1'b1;
        ram_wdata = cur.color ? (ram_rdata | pmask) : (ram_rdata & ~pmask);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      addr      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (addr == LAST_ADDR) begin
            state <= S_IDLE;
          end else begin
            addr <= addr + AW'(1);
          end
        end
        S_IDLE: begin
          if (!q_empty) begin
            cur <= q_cmd;
            case (q_cmd.op)
              OP_FILL: begin
                addr  <= '0;
                state <= S_FILL;
              end
              OP_RECT: begin
                col      <= q_cmd.x_first;
                page     <= q_cmd.page_first;
                row_base <= first_base;
                addr     <= first_base + AW'(q_cmd.x_first);
                state    <= S_RMW_RD;
              end
              OP_WRITE: begin
                addr  <= AW'(q_cmd.address);
                state <= S_WRITE;
              end
              OP_READ: begin
                addr  <= AW'(q_cmd.address);
                state <= S_READ;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_FILL: begin
          if (addr == LAST_ADDR) begin
            state <= S_DONE;
          end else begin
            addr <= addr + AW'(1);
          end
        end
        S_WRITE, S_READ: begin
          state <= S_DONE;
        end
        S_RMW_RD: begin
          state <= S_RMW_WR;
        end
        S_RMW_WR: begin
          if (col == cur.x_last) begin
            if (page == cur.page_last) begin
              state <= S_DONE;
            end else begin
              page     <= page + PAGE_W'(1);
              row_base <= row_base + ROW_STEP;
              addr     <= row_base + ROW_STEP + AW'(cur.x_first);
              col      <= cur.x_first;
              state    <= S_RMW_RD;
            end
          end else begin
            col   <= col + 8'd1;
            addr  <= addr + AW'(1);
            state <= S_RMW_RD;
          end
        end
        S_DONE: begin
          if (res_free) begin
            out_valid <= 1'b1;
            read_data <= (cur.op == OP_READ) ? ram_rdata : 8'h00;
            status    <= cur.status;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// File: design/mono_page_framebuffer_engine.sv
// ----------------------------------------------------------------------------
// mono_page_framebuffer_engine
// one-bit-per-pixel page framebuffer with fill, pixel, rectangle and byte access
// ----------------------------------------------------------------------------
// Pixel (x, y) lives in byte x + (y/8)*DISP_WIDTH at bit y%8; every command returns
// exactly one result. After reset the store is cleared one byte per cycle, with
// in_ready low. Commands pass through a two-entry queue, so up to two more commands
// are taken while one runs. In the execution unit a read or byte write touches one
// byte, a fill writes every byte of the store, and a pixel or rectangle reads and
// then writes back each touched byte (columns times pages), since the read data of
// the store is registered.
module mono_page_framebuffer_engine import mpfe_pkg::*; #(
  parameter int DISP_WIDTH  = 128,
  parameter int DISP_HEIGHT = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] func,
  input  logic [7:0] x,
  input  logic [7:0] y,
  input  logic [7:0] width,
  input  logic [7:0] height,
  input  logic       color,
  input  logic [9:0] address,
  input  logic [7:0] data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] read_data,
  output logic       status
);

  cmd_t push_cmd;
  cmd_t pop_cmd;
  logic push;
  logic pop;
  logic q_full;
  logic q_empty;
  logic clearing;

  mpfe_front #(
    .DISP_WIDTH  (DISP_WIDTH),
    .DISP_HEIGHT (DISP_HEIGHT)
  ) u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .x        (x),
    .y        (y),
    .width    (width),
    .height   (height),
    .color    (color),
    .address  (address),
    .data     (data),
    .q_full   (q_full),
    .clearing (clearing),
    .push     (push),
    .cmd      (push_cmd)
  );

  mpfe_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .pop_cmd  (pop_cmd)
  );

  mpfe_back #(
    .DISP_WIDTH  (DISP_WIDTH),
    .DISP_HEIGHT (DISP_HEIGHT)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_cmd     (pop_cmd),
    .pop       (pop),
    .clearing  (clearing),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_data (read_data),
    .status    (status)
  );

endmodule

// File: design/mpfe_checker.sv
// ----------------------------------------------------------------------------
// mpfe_checker
// port-level checks of the page framebuffer engine, bound to the top level
// ----------------------------------------------------------------------------
module mpfe_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] read_data,
  input logic       status
);

  // stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(status))
    else $error("result changed while stalled");

  // no result right after reset
  a_rst_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // store clearing blocks commands after reset
  a_rst_clear: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("command taken during clearing");

  // a command rejected with error status never returns data
  a_status_data: assert property (@(posedge clk) disable iff (rst)
    out_valid && status |-> read_data == 8'd0)
    else $error("data returned with error status");

endmodule

bind mono_page_framebuffer_engine mpfe_checker u_mpfe_checker (.*);

// File: tb/mono_page_framebuffer_checker.sv
// ----------------------------------------------------------------------------
// mono_page_framebuffer_checker
// watches both channels of the page framebuffer engine, keeps a shadow copy of
// the frame store, works out the reply of every accepted command and compares
// each returned reply field by field against the oldest one still outstanding
// ----------------------------------------------------------------------------
package mpfe_tb_pkg;

  localparam int FB_WIDTH      = 128;
  localparam int FB_HEIGHT     = 64;
  localparam int ROWS_PER_PAGE = 8;
  localparam int ROW_BIT_MASK  = 7;
  localparam int FB_PAGES      = (FB_HEIGHT + ROWS_PER_PAGE - 1) / ROWS_PER_PAGE;
  localparam int FB_BYTES      = FB_WIDTH * FB_PAGES;

  typedef enum logic [2:0] {
    FN_FILL   = 3'd0,
    FN_PIXEL  = 3'd1,
    FN_RECT   = 3'd2,
    FN_WRITE  = 3'd3,
    FN_READ   = 3'd4,
    FN_SPARE5 = 3'd5,
    FN_SPARE6 = 3'd6,
    FN_SPARE7 = 3'd7
  } func_e;

  typedef struct packed {
    logic [7:0] read_data;
    logic       status;
  } frame_reply_t;

endpackage

module mono_page_framebuffer_checker (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [2:0] func,
  input  logic [7:0] x,
  input  logic [7:0] y,
  input  logic [7:0] width,
  input  logic [7:0] height,
  input  logic       color,
  input  logic [9:0] address,
  input  logic [7:0] data,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] read_data,
  input  logic       status,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import mpfe_tb_pkg::*;

  logic [7:0]   frame_copy [FB_BYTES];
  frame_reply_t pending_replies [$];

  function automatic void plot_pixel(int col, int row, logic c);
    int         idx;
    logic [7:0] bit_sel;
    idx = col + (row / ROWS_PER_PAGE) * FB_WIDTH;
    bit_sel = 8'd1 << (row & ROW_BIT_MASK);
    frame_copy[idx] = c ? (frame_copy[idx] | bit_sel) : (frame_copy[idx] & ~bit_sel);
  endfunction

  function automatic frame_reply_t run_frame_command(
    func_e f, logic [7:0] px, logic [7:0] py, logic [7:0] w, logic [7:0] h,
    logic c, logic [9:0] a, logic [7:0] d);
    frame_reply_t r;
    int           col_end;
    int           row_end;
    r = '0;
    case (f)
      FN_FILL: begin
        for (int i = 0; i < FB_BYTES; i++) frame_copy[i] = d;
      end
      FN_PIXEL: begin
        if (px >= FB_WIDTH || py >= FB_HEIGHT) r.status = 1'b1;
        else plot_pixel(int'(px), int'(py), c);
      end
      FN_RECT: begin
        if (px >= FB_WIDTH || py >= FB_HEIGHT) begin
          r.status = 1'b1;
        end else begin
          // pixels past the right or bottom edge are dropped
          col_end = int'(px) + int'(w);
          row_end = int'(py) + int'(h);
          if (col_end > FB_WIDTH) col_end = FB_WIDTH;
          if (row_end > FB_HEIGHT) row_end = FB_HEIGHT;
          for (int row = int'(py); row < row_end; row++)
            for (int col = int'(px); col < col_end; col++) plot_pixel(col, row, c);
        end
      end
      FN_WRITE: begin
        if (a >= FB_BYTES) r.status = 1'b1;
        else frame_copy[a] = d;
      end
      FN_READ: begin
        if (a >= FB_BYTES) r.status = 1'b1;
        else r.read_data = frame_copy[a];
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    frame_reply_t want;
    int           errs;
    errs = 0;
    if (rst) begin
      for (int i = 0; i < FB_BYTES; i++) frame_copy[i] = '0;
      pending_replies.delete();
      fail_count <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_replies.size() == 0) begin
          $display("%0t: reply with no transaction outstanding: expected none, actual %0h/%0b",
                   $time, read_data, status);
          errs++;
        end else begin
          want = pending_replies.pop_front();
          if (read_data !== want.read_data) begin
            $display("%0t: read_data expected %0h actual %0h", $time, want.read_data,
                     read_data);
            errs++;
          end
          if (status !== want.status) begin
            $display("%0t: status expected %0b actual %0b", $time, want.status, status);
            errs++;
          end
        end
      end
      if (in_valid && in_ready)
        pending_replies.push_back(run_frame_command(func_e'(func), x, y, width, height,
                                                    color, address, data));
      fail_count <= fail_count + errs;
    end
    pending <= pending_replies.size();
  end

endmodule

// File: tb/mono_page_framebuffer_engine_tb.sv
// ----------------------------------------------------------------------------
// mono_page_framebuffer_engine_tb
// drives directed and random drawing, fill and byte commands into the engine
// with random gaps and output stalls; the checker beside the block predicts
// and compares every reply, this top only makes stimulus and gives the verdict
// ----------------------------------------------------------------------------
module mono_page_framebuffer_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mpfe_tb_pkg::*;

  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int DRAIN_CYCLES = 64;
  localparam int RANDOM_ITEMS = 1950;

  logic       clk;
  logic       rst;
  logic       in_valid;
  logic       in_ready;
  logic [2:0] func;
  logic [7:0] x;
  logic [7:0] y;
  logic [7:0] width;
  logic [7:0] height;
  logic       color;
  logic [9:0] address;
  logic [7:0] data;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] read_data;
  logic       status;
  int         fail_count;
  int         pending;
  int         cycle_count;
  bit         send_burst;

  mono_page_framebuffer_engine #(
    .DISP_WIDTH (FB_WIDTH),
    .DISP_HEIGHT(FB_HEIGHT)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .x        (x),
    .y        (y),
    .width    (width),
    .height   (height),
    .color    (color),
    .address  (address),
    .data     (data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .read_data(read_data),
    .status   (status)
  );

  mono_page_framebuffer_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .x         (x),
    .y         (y),
    .width     (width),
    .height    (height),
    .color     (color),
    .address   (address),
    .data      (data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .read_data (read_data),
    .status    (status),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  task automatic issue_command(input func_e f, input logic [7:0] px, input logic [7:0] py,
                               input logic [7:0] w, input logic [7:0] h, input logic c,
                               input logic [9:0] a, input logic [7:0] d);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    x        <= px;
    y        <= py;
    width    <= w;
    height   <= h;
    color    <= c;
    address  <= a;
    data     <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_all_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // reply side stalls
  initial begin
    int stall;
    int taken;
    bit recv_burst;
    taken = 0;
    recv_burst = 1'b0;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (taken % 150 == 0) recv_burst = ($urandom_range(0, 3) == 0);
      stall = recv_burst ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("mono_page_framebuffer_engine: mismatch");
    $finish;
  end

  initial begin
    int          pick;
    func_e       f;
    logic [7:0]  rx;
    logic [7:0]  ry;
    logic [7:0]  rw;
    logic [7:0]  rh;
    logic        rc;
    logic [9:0]  ra;
    logic [7:0]  rd;
    logic [9:0]  recent_addr;
    rst      <= 1'b1;
    in_valid <= 1'b0;
    func     <= '0;
    x        <= '0;
    y        <= '0;
    width    <= '0;
    height   <= '0;
    color    <= 1'b0;
    address  <= '0;
    data     <= '0;
    send_burst = 1'b0;
    recent_addr = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    issue_command(FN_READ,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 10'd0,    8'h00);
    issue_command(FN_WRITE, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 10'd1023, 8'hff);
    issue_command(FN_READ,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 10'd1023, 8'h00);
    issue_command(FN_WRITE, 8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 10'd0,    8'ha5);
    issue_command(FN_PIXEL, 8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 10'd0,    8'h00);
    issue_command(FN_READ,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 10'd0,    8'h00);
    issue_command(FN_PIXEL, 8'd127, 8'd63,  8'd0,   8'd0,   1'b1, 10'd0,    8'h00);
    issue_command(FN_PIXEL, 8'd127, 8'd63,  8'd0,   8'd0,   1'b0, 10'd0,    8'h00);
    issue_command(FN_READ,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 10'd1023, 8'h00);
    issue_command(FN_PIXEL, 8'd128, 8'd0,   8'd0,   8'd0,   1'b1, 10'd0,    8'h00);
    issue_command(FN_PIXEL, 8'd0,   8'd64,  8'd0,   8'd0,   1'b1, 10'd0,    8'h00);
    issue_command(FN_PIXEL, 8'd255, 8'd255, 8'd255, 8'd255, 1'b1, 10'd1023, 8'hff);
    issue_command(FN_RECT,  8'd120, 8'd60,  8'd255, 8'd255, 1'b1, 10'd0,    8'h00);
    issue_command(FN_READ,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 10'd1016, 8'h00);
    issue_command(FN_RECT,  8'd10,  8'd10,  8'd0,   8'd5,   1'b1, 10'd0,    8'h00);
    issue_command(FN_RECT,  8'd10,  8'd10,  8'd5,   8'd0,   1'b1, 10'd0,    8'h00);
    issue_command(FN_RECT,  8'd128, 8'd0,   8'd4,   8'd4,   1'b1, 10'd0,    8'h00);
    issue_command(FN_RECT,  8'd0,   8'd255, 8'd4,   8'd4,   1'b1, 10'd0,    8'h00);
    issue_command(FN_RECT,  8'd0,   8'd0,   8'd255, 8'd255, 1'b0, 10'd0,    8'h00);
    issue_command(FN_READ,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 10'd1016, 8'h00);
    issue_command(FN_FILL,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 10'd0,    8'hff);
    issue_command(FN_FILL,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 10'd0,    8'h00);
    issue_command(FN_FILL,  8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 10'd0,    8'h5a);
    issue_command(FN_SPARE5, 8'd3,  8'd4,   8'd5,   8'd6,   1'b1, 10'd7,    8'h3c);
    issue_command(FN_SPARE6, 8'd0,  8'd0,   8'd0,   8'd0,   1'b0, 10'd0,    8'h00);
    wait_all_replies();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 100 == 0) send_burst = ($urandom_range(0, 3) == 0);
      if (n == RANDOM_ITEMS / 2) wait_all_replies();
      pick = $urandom_range(0, 99);
      rx = 8'($urandom_range(0, 255));
      ry = 8'($urandom_range(0, 255));
      rw = 8'($urandom_range(0, 255));
      rh = 8'($urandom_range(0, 255));
      rc = 1'($urandom_range(0, 1));
      ra = 10'($urandom_range(0, 1023));
      rd = 8'($urandom_range(0, 255));
      if (pick < 2) begin
        f = FN_FILL;
      end else if (pick < 32) begin
        f = FN_PIXEL;
        if ($urandom_range(0, 9) != 0) begin
          rx = 8'($urandom_range(0, FB_WIDTH - 1));
          ry = 8'($urandom_range(0, FB_HEIGHT - 1));
          recent_addr = 10'(int'(rx) + (int'(ry) / ROWS_PER_PAGE) * FB_WIDTH);
        end
      end else if (pick < 52) begin
        f = FN_RECT;
        if ($urandom_range(0, 9) != 0) begin
          rx = 8'($urandom_range(0, FB_WIDTH - 1));
          ry = 8'($urandom_range(0, FB_HEIGHT - 1));
          recent_addr = 10'(int'(rx) + (int'(ry) / ROWS_PER_PAGE) * FB_WIDTH);
        end
        // mostly small shapes, a few with random sizes up to 255
        if ($urandom_range(0, 19) != 0) begin
          rw = 8'($urandom_range(0, 15));
          rh = 8'($urandom_range(0, 15));
        end
      end else if (pick < 72) begin
        f = FN_WRITE;
        if ($urandom_range(0, 1) == 0) ra = recent_addr;
        else recent_addr = ra;
      end else if (pick < 97) begin
        f = FN_READ;
        if ($urandom_range(0, 1) == 0) ra = recent_addr;
      end else begin
        f = func_e'($urandom_range(int'(FN_SPARE5), int'(FN_SPARE7)));
      end
      issue_command(f, rx, ry, rw, rh, rc, ra, rd);
    end

    wait_all_replies();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("mono_page_framebuffer_engine: match");
    end else begin
      $display("mono_page_framebuffer_engine: mismatch");
    end
    $finish;
  end

endmodule

// File: mono_page_framebuffer_engine.f
design/mpfe_pkg.sv
design/mpfe_ram.sv
design/mpfe_front.sv
design/mpfe_queue.sv
design/mpfe_back.sv
design/mono_page_framebuffer_engine.sv
design/mpfe_checker.sv
tb/mono_page_framebuffer_checker.sv
tb/mono_page_framebuffer_engine_tb.sv
